[design/lmwc_pkg.sv]
// shared constants, types and the output mixing function of the lag mwc generator
// no dependencies

package lmwc_pkg;

	localparam int WORD_W      = 64;
	localparam int HALF_W      = 32;
	localparam int LAG_DEFAULT = 256;
	localparam int ROT_A       = 17;
	localparam int ROT_B       = 53;

	localparam logic [WORD_W-1:0] MWC_MULT   = 64'hbd4e5d1a2d5969e5;
	localparam logic [WORD_W-1:0] CARRY_SEED = 64'd1234567890;
	localparam logic [WORD_W-1:0] EXP_OR     = 64'h0000000040000005;
	localparam logic [WORD_W-1:0] EXP_MULT   = 64'd6906969069;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [2*WORD_W-1:0] dword_t;
	typedef logic [HALF_W-1:0]   half_t;

	typedef struct packed {
		logic first;
		logic mul;
		logic acc;
	} mac_ctl_t;

	function automatic word_t mix_rot(input word_t u);
		word_t r_a;
		word_t r_b;
		r_a = (u << ROT_A) | (u >> (WORD_W - ROT_A));
		r_b = (u << ROT_B) | (u >> (WORD_W - ROT_B));
		return u ^ r_a ^ r_b;
	endfunction

endpackage

[design/lmwc_if.sv]
// valid/ready channel interfaces of the lag mwc generator: request, result, config
// no dependencies

interface lmwc_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] seed_low;
	logic [63:0] seed_high;

	modport source (output valid, output kind, output seed_low, output seed_high,
		input ready);
	modport sink (input valid, input kind, input seed_low, input seed_high,
		output ready);
endinterface

interface lmwc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

interface lmwc_cfg_if;
	logic valid;
	logic ready;
	logic scrambled_mode;

	modport source (output valid, output scrambled_mode, input ready);
	modport sink (input valid, input scrambled_mode, output ready);
endinterface

[design/lmwc_mac.sv]
// shared 32x32 multiplier with a 128-bit shifted accumulator
// depends on lmwc_pkg

module lmwc_mac (
	input  logic              clk,
	input  lmwc_pkg::mac_ctl_t ctl,
	input  lmwc_pkg::half_t   op_a,
	input  lmwc_pkg::half_t   op_b,
	input  logic [1:0]        shift,
	input  lmwc_pkg::dword_t  init,
	output lmwc_pkg::dword_t  acc
);
	import lmwc_pkg::*;

	word_t      prod_q;
	logic [1:0] sh_q;
	dword_t     acc_q;
	dword_t     addend;

	assign addend = dword_t'(prod_q) << {sh_q, 5'b00000};
	assign acc    = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= word_t'(op_a) * word_t'(op_b);
			sh_q   <= shift;
		end
		if (ctl.first) begin
			acc_q <= init;
		end else if (ctl.acc) begin
			acc_q <= acc_q + addend;
		end
	end

endmodule

[design/lag256_add_with_carry_prng.sv]
// Lag-LAG multiply-with-carry generator with 64-bit words. A draw beat (kind 0)
// returns one random_word; a reseed beat (kind 1) returns nothing and keeps the
// block busy while it fills the ring from the seed expander and then warms it up.
// Both are paced by the single 32x32 multiplier: each generator step uses it four
// times, each seed expander step six times, and the ring is read and written
// through one memory. The ring holds no defined values until the first reseed. A
// finished result waits in an output register while the next beat is taken;
// scrambled_mode may be written at any idle time and applies to later draws.
// depends on lmwc_pkg, lmwc_if and lmwc_mac

module lag256_add_with_carry_prng #(
	parameter int LAG = lmwc_pkg::LAG_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	lmwc_req_if.sink   req,
	lmwc_rsp_if.source rsp,
	lmwc_cfg_if.sink   cfg
);
	import lmwc_pkg::*;

	localparam int POS_W  = $clog2(LAG);
	localparam int WARM_N = LAG * LAG;
	localparam int WARM_W = $clog2(WARM_N);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(LAG - 1);
	localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(WARM_N - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_MAC  = 6'b000100,
		ST_WB   = 6'b001000,
		ST_SUPD = 6'b010000,
		ST_XFIN = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_MWC,
		PH_SQ,
		PH_UM
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic              draw_q;
	logic [2:0]        k_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  fill_q;
	logic [WARM_W-1:0] warm_q;
	logic              sel_q;
	logic              scrambled_q;
	logic              out_valid_q;
	word_t             carry_q;
	word_t             exp_q [2];
	word_t             w_q;
	word_t             x_cur_q;
	word_t             x_nxt_q;
	word_t             out_word_q;
	word_t             mem [LAG];

	logic [POS_W-1:0] pos_nxt;
	word_t            s_cur;
	word_t            a_word;
	word_t            b_word;
	logic [2:0]       mac_last;
	mac_ctl_t         mac_ctl;
	half_t            op_a;
	half_t            op_b;
	logic [1:0]       shift;
	dword_t           mac_init;
	dword_t           acc;
	word_t            mix_acc;
	word_t            fill_word;
	logic             wb_go;
	logic             mem_we;
	logic [POS_W-1:0] mem_wa;
	word_t            mem_wd;

	assign pos_nxt   = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign s_cur     = exp_q[sel_q];
	assign mix_acc   = mix_rot(acc[WORD_W-1:0]);
	assign fill_word = w_q + mix_acc;
	assign wb_go     = draw_q ? (!out_valid_q || rsp.ready) : 1'b1;

	assign req.ready       = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_word_q;

	// operand selection for the shared multiplier
	always_comb begin
		case (phase_q)
			PH_SQ: begin
				a_word = s_cur;
				b_word = s_cur;
			end
			PH_UM: begin
				a_word = s_cur ^ (s_cur >> HALF_W);
				b_word = EXP_MULT;
			end
			default: begin
				a_word = MWC_MULT;
				b_word = x_cur_q;
			end
		endcase
		mac_last      = (phase_q == PH_MWC) ? 3'd4 : 3'd3;
		op_a          = k_q[1] ? a_word[WORD_W-1:HALF_W] : a_word[HALF_W-1:0];
		op_b          = k_q[0] ? b_word[WORD_W-1:HALF_W] : b_word[HALF_W-1:0];
		shift         = {1'b0, k_q[1]} + {1'b0, k_q[0]};
		mac_init      = (phase_q == PH_MWC) ? dword_t'(x_nxt_q) + dword_t'(carry_q) : '0;
		mac_ctl.first = (state_q == ST_MAC) && (k_q == 3'd0);
		mac_ctl.mul   = (state_q == ST_MAC) && (k_q < mac_last);
		mac_ctl.acc   = (state_q == ST_MAC) && (k_q != 3'd0);
	end

	lmwc_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.op_a  (op_a),
		.op_b  (op_b),
		.shift (shift),
		.init  (mac_init),
		.acc   (acc)
	);

	// ring memory, one write and two registered reads
	always_comb begin
		mem_we = ((state_q == ST_WB) && wb_go) || ((state_q == ST_XFIN) && sel_q);
		mem_wa = (state_q == ST_XFIN) ? fill_q : pos_q;
		mem_wd = (state_q == ST_XFIN) ? fill_word : acc[WORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_RD) begin
			x_cur_q <= mem[pos_q];
			x_nxt_q <= mem[pos_nxt];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_WB) && draw_q && wb_go) begin
			out_word_q <= scrambled_q ? mix_rot(x_cur_q) : acc[WORD_W-1:0];
		end
		if ((state_q == ST_XFIN) && !sel_q) begin
			w_q <= mix_acc;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MWC;
			draw_q      <= 1'b0;
			k_q         <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			warm_q      <= '0;
			sel_q       <= 1'b0;
			scrambled_q <= 1'b1;
			out_valid_q <= 1'b0;
			carry_q     <= CARRY_SEED;
			exp_q       <= '{default: '0};
		end else begin
			if (cfg.valid && cfg.ready) begin
				scrambled_q <= cfg.scrambled_mode;
			end
			if ((state_q == ST_WB) && draw_q && wb_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (req.valid) begin
						if (req.kind) begin
							exp_q[0] <= req.seed_low;
							exp_q[1] <= req.seed_high;
							pos_q    <= '0;
							carry_q  <= CARRY_SEED;
							fill_q   <= '0;
							sel_q    <= 1'b0;
							draw_q   <= 1'b0;
							phase_q  <= PH_SQ;
							state_q  <= ST_MAC;
						end else begin
							draw_q  <= 1'b1;
							phase_q <= PH_MWC;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					k_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (k_q == mac_last) begin
						k_q <= '0;
						case (phase_q)
							PH_SQ:   state_q <= ST_SUPD;
							PH_UM:   state_q <= ST_XFIN;
							default: state_q <= ST_WB;
						endcase
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						carry_q <= acc[2*WORD_W-1:WORD_W];
						pos_q   <= pos_nxt;
						if (draw_q) begin
							state_q <= ST_IDLE;
						end else if (warm_q == WARM_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							warm_q  <= warm_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_SUPD: begin
					exp_q[sel_q] <= s_cur + (acc[WORD_W-1:0] | EXP_OR);
					phase_q      <= PH_UM;
					state_q      <= ST_MAC;
				end
				ST_XFIN: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						phase_q <= PH_SQ;
						state_q <= ST_MAC;
					end else begin
						sel_q <= 1'b0;
						if (fill_q == POS_LAST) begin
							phase_q <= PH_MWC;
							warm_q  <= '0;
							pos_q   <= '0;
							state_q <= ST_RD;
						end else begin
							fill_q  <= fill_q + 1'b1;
							phase_q <= PH_SQ;
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= POS_LAST) && (fill_q <= POS_LAST))
		else $error("ring position out of range");

	a_mac_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (k_q <= mac_last))
		else $error("multiplier step count overran");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past((state_q == ST_WB) && draw_q))
		else $error("result beat raised outside a draw write-back");

	a_draw_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WB) && draw_q && wb_go) |=> ((state_q == ST_IDLE) && out_valid_q))
		else $error("draw did not complete into the output register");
`endif

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for lag256_add_with_carry_prng: reseeds, draws in both output modes,
// random idling on both channels and a long result hold-off, checked against a shadow generator
// depends on lmwc_pkg, lmwc_if and the design under test

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lmwc_pkg::*;

	localparam int ITEM_TOTAL    = 1850;
	localparam int CALM_TAIL     = 250;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 4000000;

	localparam logic KIND_DRAW      = 1'b0;
	localparam logic KIND_SEED      = 1'b1;
	localparam logic MODE_LINEAR    = 1'b0;
	localparam logic MODE_SCRAMBLED = 1'b1;

	class mwc_shadow;
		word_t       ring[LAG_DEFAULT];
		word_t       carry;
		int unsigned pos;
		logic        mode;
		word_t       pending_words[$];
		int          mismatches;
		int          reseeds;
		int          linear_draws;
		int          scrambled_draws;
		int          checked;

		function new();
			foreach (ring[k]) ring[k] = '0;
			carry = CARRY_SEED;
			pos = 0;
			mode = MODE_SCRAMBLED;
			mismatches = 0;
			reseeds = 0;
			linear_draws = 0;
			scrambled_draws = 0;
			checked = 0;
		endfunction

		function word_t spin_mix(word_t u);
			return u ^ {u[46:0], u[63:47]} ^ {u[10:0], u[63:11]};
		endfunction

		function word_t expand(inout word_t s);
			word_t u;
			s = s + ((s * s) | EXP_OR);
			u = s ^ (s >> 32);
			u = u * EXP_MULT;
			return spin_mix(u);
		endfunction

		function word_t advance_ring();
			int unsigned nxt;
			dword_t      total;
			nxt = (pos + 1) % LAG_DEFAULT;
			total = {64'd0, MWC_MULT} * {64'd0, ring[pos]} + {64'd0, ring[nxt]}
				+ {64'd0, carry};
			ring[pos] = total[63:0];
			carry = total[127:64];
			pos = nxt;
			return total[63:0];
		endfunction

		function void reseed(word_t s_lo, word_t s_hi);
			word_t e0;
			word_t e1;
			e0 = s_lo;
			e1 = s_hi;
			pos = 0;
			carry = CARRY_SEED;
			for (int k = 0; k < LAG_DEFAULT; k++) begin
				ring[k] = expand(e0);
				ring[k] = ring[k] + expand(e1);
			end
			for (int n = 0; n < LAG_DEFAULT * LAG_DEFAULT; n++) void'(advance_ring());
		endfunction

		function void set_mode(logic m);
			mode = m;
		endfunction

		function void note_request(logic kind, word_t s_lo, word_t s_hi);
			word_t old;
			if (kind == KIND_SEED) begin
				reseed(s_lo, s_hi);
				reseeds++;
			end else if (mode == MODE_SCRAMBLED) begin
				old = ring[pos];
				void'(advance_ring());
				pending_words.push_back(spin_mix(old));
				scrambled_draws++;
			end else begin
				pending_words.push_back(advance_ring());
				linear_draws++;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_word(word_t got);
			word_t want;
			checked++;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("random_word %h with no draw pending", got));
			end else begin
				want = pending_words.pop_front();
				if (got !== want)
					report_mismatch($sformatf("random_word %h, expected %h", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lmwc_req_if req_if();
	lmwc_rsp_if rsp_if();
	lmwc_cfg_if cfg_if();

	lag256_add_with_carry_prng DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	mwc_shadow shadow;
	int        items_sent;
	int        stall_left;
	int        chunk;
	int        cycle_count;
	bit        idle_on;
	bit        hold_request;
	bit        pressure_done;
	bit        second_seed;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(input logic kind, input word_t s_lo, input word_t s_hi);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.kind <= kind;
		req_if.seed_low <= s_lo;
		req_if.seed_high <= s_hi;
		do @(posedge clk); while (!req_if.ready);
		shadow.note_request(kind, s_lo, s_hi);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.scrambled_mode <= m;
		do @(posedge clk); while (!cfg_if.ready);
		shadow.set_mode(m);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// result side: random stall bursts, one long hold on request
	initial begin
		rsp_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			shadow.check_word(rsp_if.random_word);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d draws outstanding",
			cycle_count, shadow.pending());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		shadow = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_DRAW;
		req_if.seed_low = '0;
		req_if.seed_high = '0;
		cfg_if.valid = 1'b0;
		cfg_if.scrambled_mode = MODE_LINEAR;
		items_sent = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		pressure_done = 1'b0;
		second_seed = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extreme seeds, then draws in the reset mode
		send_item(KIND_SEED, '0, '1);
		send_item(KIND_DRAW, '1, '0);
		send_item(KIND_DRAW, '0, '1);
		repeat (4) send_item(KIND_DRAW, rand_word(), rand_word());
		settle();
		write_mode(MODE_LINEAR);
		send_item(KIND_DRAW, '0, '0);
		send_item(KIND_DRAW, '1, '1);
		repeat (4) send_item(KIND_DRAW, rand_word(), rand_word());
		settle();
		write_mode(MODE_SCRAMBLED);
		repeat (4) send_item(KIND_DRAW, rand_word(), rand_word());

		while (items_sent < ITEM_TOTAL) begin
			settle();
			write_mode(logic'($urandom_range(0, 1)));
			// reseed once more after at least 600 items
			if (!second_seed && items_sent >= 600) begin
				second_seed = 1'b1;
				send_item(KIND_SEED, rand_word(), rand_word());
			end
			if (!pressure_done && items_sent >= 300) begin
				pressure_done = 1'b1;
				hold_request = 1'b1;
			end
			chunk = $urandom_range(40, 260);
			repeat (chunk) begin
				if (ITEM_TOTAL - items_sent <= CALM_TAIL)
					idle_on = 1'b0;
				if (items_sent < ITEM_TOTAL)
					send_item(KIND_DRAW, rand_word(), rand_word());
			end
		end
		settle();

		$display("covered %0d linear and %0d scrambled draws across %0d reseeds,",
			shadow.linear_draws, shadow.scrambled_draws, shadow.reseeds);
		$display("%0d results checked, with random idling on both channels, a %0d-cycle %s",
			shadow.checked, HOLD_CYCLES, "result hold and a calm tail");
		if (shadow.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
